/* rtl/gdda_pkg.sv */
// -----------------------------------------------------------------------------
// gdda_pkg
// Shared types, widths and codes for the grid DDA wall column caster.
// -----------------------------------------------------------------------------
package gdda_pkg;

   localparam int GRID_W_DEF     = 64;
   localparam int GRID_H_DEF     = 64;
   localparam int SCREEN_H_DEF   = 768;
   localparam int STEP_LIMIT_DEF = 128;
   localparam int QUEUE_DEPTH    = 2;

   localparam int CELL_W   = 6;
   localparam int DIR_W    = 16;
   localparam int DIST_W   = 24;
   localparam int VIEW_W   = 22;
   localparam int OFF_W    = 23;
   localparam int SIDE_W   = 32;
   localparam int PERP_W   = 24;
   localparam int HEIGHT_W = 16;
   localparam int DRAW_W   = 10;
   localparam int Q_FRAC   = 16;
   localparam int DIR_FRAC = 14;
   localparam int CSR_IDX_W = 1;

   localparam logic [PERP_W-1:0]   PERP_MAX   = '1;
   localparam logic [HEIGHT_W-1:0] HEIGHT_MAX = '1;

   localparam logic [CSR_IDX_W-1:0] CSR_VIEWER_X = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_VIEWER_Y = 1'b1;

   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_CAST  = 1'b1;

   typedef enum logic [1:0] {
      CMD_NOP,
      CMD_WRITE,
      CMD_CAST
   } cmd_kind_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_MUL,
      ST_SIDE,
      ST_STEP,
      ST_CHECK,
      ST_PREP,
      ST_PDIV,
      ST_HPREP,
      ST_HDIV,
      ST_OUT
   } back_state_type;

   typedef struct packed {
      cmd_kind_type             kind;
      logic [CELL_W-1:0]        cell_x;
      logic [CELL_W-1:0]        cell_y;
      logic                     is_wall;
      logic                     neg_x;
      logic                     neg_y;
      logic signed [DIR_W-1:0]  dir_x;
      logic signed [DIR_W-1:0]  dir_y;
      logic [DIST_W-1:0]        step_dist_x;
      logic [DIST_W-1:0]        step_dist_y;
      logic [OFF_W-1:0]         off_x;
      logic [OFF_W-1:0]         off_y;
   } cmd_type;

   typedef struct packed {
      logic [CELL_W-1:0]   hit_x;
      logic [CELL_W-1:0]   hit_y;
      logic                hit_side;
      logic [PERP_W-1:0]   perp_dist;
      logic [HEIGHT_W-1:0] column_height;
      logic [DRAW_W-1:0]   draw_top;
      logic [DRAW_W-1:0]   draw_bottom;
      logic                off_grid;
   } rsp_type;

   typedef struct packed {
      logic clearing;
      logic busy;
   } back_status_type;

endpackage

/* rtl/gdda_fifo.sv */
// -----------------------------------------------------------------------------
// gdda_fifo
// Small register queue used between the front, the back and the result port.
// -----------------------------------------------------------------------------
module gdda_fifo #(
   parameter int W     = 8,
   parameter int DEPTH = 2
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  logic [W-1:0] wr_data,
   output logic         full,
   input  logic         pop,
   output logic [W-1:0] rd_data,
   output logic         empty
);
   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [W-1:0]  store_ff [DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;
   logic          do_push, do_pop;

   assign full    = (count_ff == CW'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rd_data = store_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

/* rtl/gdda_front.sv */
// -----------------------------------------------------------------------------
// gdda_front
// Classifies incoming items and works out the clamped offsets to the first
// grid lines for a cast.
// -----------------------------------------------------------------------------
module gdda_front #(
   parameter int GRID_W = 64,
   parameter int GRID_H = 64
) (
   input  logic [gdda_pkg::VIEW_W-1:0]       viewer_x,
   input  logic [gdda_pkg::VIEW_W-1:0]       viewer_y,
   input  logic                              opcode,
   input  logic [gdda_pkg::CELL_W-1:0]       cell_x,
   input  logic [gdda_pkg::CELL_W-1:0]       cell_y,
   input  logic                              is_wall,
   input  logic signed [gdda_pkg::DIR_W-1:0] dir_x,
   input  logic signed [gdda_pkg::DIR_W-1:0] dir_y,
   input  logic [gdda_pkg::DIST_W-1:0]       step_dist_x,
   input  logic [gdda_pkg::DIST_W-1:0]       step_dist_y,
   output gdda_pkg::cmd_type                 cmd
);
   import gdda_pkg::*;

   localparam int DW = OFF_W + 1;

   logic [DW-1:0] diff_x, diff_y;

   // offset from viewer to the first line, sign in the top bit
   function automatic logic [DW-1:0] line_offset(
      input logic              neg,
      input logic [CELL_W-1:0] cell_idx,
      input logic [VIEW_W-1:0] view
   );
      logic [DW-1:0] lo;
      logic [DW-1:0] hi;
      logic [DW-1:0] vw;
      lo = DW'({cell_idx, Q_FRAC'(0)});
      hi = DW'({(CELL_W + 1)'(cell_idx) + (CELL_W + 1)'(1), Q_FRAC'(0)});
      vw = DW'(view);
      return neg ? (vw - lo) : (hi - vw);
   endfunction

   assign diff_x = line_offset(dir_x[DIR_W-1], cell_x, viewer_x);
   assign diff_y = line_offset(dir_y[DIR_W-1], cell_y, viewer_y);

   always_comb begin
      cmd.cell_x      = cell_x;
      cmd.cell_y      = cell_y;
      cmd.is_wall     = is_wall;
      cmd.neg_x       = dir_x[DIR_W-1];
      cmd.neg_y       = dir_y[DIR_W-1];
      cmd.dir_x       = dir_x;
      cmd.dir_y       = dir_y;
      cmd.step_dist_x = step_dist_x;
      cmd.step_dist_y = step_dist_y;
      cmd.off_x       = diff_x[DW-1] ? '0 : diff_x[OFF_W-1:0];
      cmd.off_y       = diff_y[DW-1] ? '0 : diff_y[OFF_W-1:0];
      if (opcode == OP_CAST) begin
         cmd.kind = CMD_CAST;
      end else if ((int'(cell_x) < GRID_W) && (int'(cell_y) < GRID_H)) begin
         cmd.kind = CMD_WRITE;
      end else begin
         cmd.kind = CMD_NOP;
      end
   end

endmodule

/* rtl/gdda_div.sv */
// -----------------------------------------------------------------------------
// gdda_div
// Restoring unsigned divider, one quotient bit per cycle.
// -----------------------------------------------------------------------------
module gdda_div #(
   parameter int DVD_W = 40,
   parameter int DVS_W = 24
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DVD_W-1:0] dividend,
   input  logic [DVS_W-1:0] divisor,
   output logic             done,
   output logic [DVD_W-1:0] quotient
);
   localparam int CW = $clog2(DVD_W + 1);

   logic [DVS_W-1:0] rem_ff, rem_in, dvs_ff, dvs_in;
   logic [DVD_W-1:0] quo_ff, quo_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic             busy_ff, busy_in, done_ff, done_in;
   logic [DVS_W:0]   trial, diff;

   assign trial    = {rem_ff, quo_ff[DVD_W-1]};
   assign diff     = trial - {1'b0, dvs_ff};
   assign done     = done_ff;
   assign quotient = quo_ff;

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend;
         dvs_in  = divisor;
         cnt_in  = CW'(DVD_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!diff[DVS_W]) begin
            rem_in = diff[DVS_W-1:0];
            quo_in = {quo_ff[DVD_W-2:0], 1'b1};
         end else begin
            rem_in = trial[DVS_W-1:0];
            quo_in = {quo_ff[DVD_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

endmodule

/* rtl/gdda_back.sv */
// -----------------------------------------------------------------------------
// gdda_back
// Owns the wall grid, runs grid writes and the DDA walk, then the distance
// and column height divisions.
// -----------------------------------------------------------------------------
module gdda_back #(
   parameter int GRID_W     = 64,
   parameter int GRID_H     = 64,
   parameter int SCREEN_H   = 768,
   parameter int STEP_LIMIT = 128
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [gdda_pkg::VIEW_W-1:0] viewer_x,
   input  logic [gdda_pkg::VIEW_W-1:0] viewer_y,
   input  gdda_pkg::cmd_type           cmd,
   input  logic                        cmd_empty,
   output logic                        cmd_pop,
   input  logic                        rsp_full,
   output logic                        rsp_push,
   output gdda_pkg::rsp_type           rsp,
   output gdda_pkg::back_status_type   status
);
   import gdda_pkg::*;

   localparam int DEPTH  = GRID_W * GRID_H;
   localparam int AW     = $clog2(DEPTH);
   localparam int GMAX   = (GRID_W > GRID_H) ? GRID_W : GRID_H;
   localparam int CMAX   = (GMAX > 64) ? GMAX : 64;
   localparam int XW     = $clog2(CMAX + 2) + 1;
   localparam int NW     = XW + Q_FRAC + 2;
   localparam int SCR_W  = $clog2(SCREEN_H + 1);
   localparam int PD_W   = NW + DIR_FRAC;
   localparam int HD_W   = SCR_W + Q_FRAC;
   localparam int DVD_W  = (PD_W > HD_W) ? PD_W : HD_W;
   localparam int SW     = $clog2(STEP_LIMIT + 1);
   localparam int PROD_W = OFF_W + DIST_W;
   localparam int TW     = ((SCR_W > HEIGHT_W) ? SCR_W : HEIGHT_W) + 2;

   back_state_type state_ff, state_in;

   logic                     grid_mem [DEPTH];
   logic                     rd_data_ff;
   logic [AW-1:0]            rd_addr, wr_addr, clr_cnt_ff, clr_cnt_in;
   logic                     mem_we, mem_wd;

   logic signed [XW-1:0]     walk_x_ff, walk_y_ff, walk_x_nx, walk_y_nx, nx, ny;
   logic                     neg_x_ff, neg_y_ff, side_ff, oob_ff, off_grid_ff;
   logic signed [DIR_W-1:0]  dir_x_ff, dir_y_ff;
   logic [DIST_W-1:0]        ddx_ff, ddy_ff;
   logic [OFF_W-1:0]         off_x_ff, off_y_ff;
   logic [PROD_W-1:0]        prod_x_ff, prod_y_ff;
   logic [SIDE_W-1:0]        side_x_ff, side_y_ff, side_x_nx, side_y_nx;
   logic [SIDE_W:0]          sum_x, sum_y;
   logic [SW-1:0]            steps_ff;
   logic [PERP_W-1:0]        perp_ff;
   logic [HEIGHT_W-1:0]      height_ff;
   logic                     step_x, at_limit, oob_nx;

   logic signed [XW-1:0]     walk_sel;
   logic signed [XW:0]       cell_adj;
   logic signed [NW-1:0]     num;
   logic [NW-1:0]            num_mag;
   logic signed [DIR_W-1:0]  dir_sel;
   logic [DIR_W:0]           dir_mag;
   logic                     perp_special;
   logic [PERP_W-1:0]        perp_special_val;

   logic                     div_start, div_done;
   logic [DVD_W-1:0]         div_dividend, div_quotient;
   logic [PERP_W-1:0]        div_divisor;
   logic signed [TW-1:0]     top_w, bot_w;

   gdda_div #(.DVD_W(DVD_W), .DVS_W(PERP_W)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quotient)
   );

   // one DDA step
   assign step_x    = side_x_ff < side_y_ff;
   assign sum_x     = {1'b0, side_x_ff} + (SIDE_W + 1)'(ddx_ff);
   assign sum_y     = {1'b0, side_y_ff} + (SIDE_W + 1)'(ddy_ff);
   assign side_x_nx = sum_x[SIDE_W] ? '1 : sum_x[SIDE_W-1:0];
   assign side_y_nx = sum_y[SIDE_W] ? '1 : sum_y[SIDE_W-1:0];
   assign walk_x_nx = neg_x_ff ? walk_x_ff - XW'(1) : walk_x_ff + XW'(1);
   assign walk_y_nx = neg_y_ff ? walk_y_ff - XW'(1) : walk_y_ff + XW'(1);
   assign nx        = step_x ? walk_x_nx : walk_x_ff;
   assign ny        = step_x ? walk_y_ff : walk_y_nx;
   assign oob_nx    = (nx < 0) || (ny < 0) || (int'(nx) >= GRID_W) || (int'(ny) >= GRID_H);
   assign rd_addr   = AW'(int'(ny) * GRID_W + int'(nx));
   assign wr_addr   = AW'(int'(cmd.cell_y) * GRID_W + int'(cmd.cell_x));
   assign at_limit  = (steps_ff == SW'(STEP_LIMIT));

   // perpendicular distance numerator and sign handling
   assign walk_sel = side_ff ? walk_y_ff : walk_x_ff;
   assign cell_adj = (XW + 1)'(walk_sel)
                     + (XW + 1)'(signed'({1'b0, side_ff ? neg_y_ff : neg_x_ff}));
   assign num      = (NW'(cell_adj) <<< Q_FRAC)
                     - signed'(NW'(side_ff ? viewer_y : viewer_x));
   assign num_mag  = num[NW-1] ? NW'(-num) : NW'(num);
   assign dir_sel  = side_ff ? dir_y_ff : dir_x_ff;
   assign dir_mag  = dir_sel[DIR_W-1] ? (DIR_W + 1)'(-(DIR_W + 1)'(dir_sel))
                                      : (DIR_W + 1)'(dir_sel);

   always_comb begin
      perp_special     = 1'b0;
      perp_special_val = '0;
      if (dir_sel == '0) begin
         perp_special     = 1'b1;
         perp_special_val = PERP_MAX;
      end else if ((num != '0) && (num[NW-1] != dir_sel[DIR_W-1])) begin
         perp_special = 1'b1;
      end
   end

   // slice extent around the shifted screen center
   assign top_w = TW'(SCREEN_H / 2) - TW'(height_ff >> 1) + TW'(SCREEN_H / 8);
   assign bot_w = TW'(SCREEN_H / 2) + TW'(height_ff >> 1) + TW'(SCREEN_H / 8);

   always_comb begin
      rsp.hit_x         = CELL_W'(walk_x_ff);
      rsp.hit_y         = CELL_W'(walk_y_ff);
      rsp.hit_side      = side_ff;
      rsp.perp_dist     = perp_ff;
      rsp.column_height = height_ff;
      rsp.draw_top      = (top_w < 0) ? '0 : DRAW_W'(top_w);
      rsp.draw_bottom   = (bot_w >= TW'(SCREEN_H)) ? DRAW_W'(SCREEN_H - 1) : DRAW_W'(bot_w);
      rsp.off_grid      = off_grid_ff;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (clr_cnt_ff == AW'(DEPTH - 1)) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (!cmd_empty && cmd.kind == CMD_CAST) state_in = ST_MUL;
         end
         ST_MUL:  state_in = ST_SIDE;
         ST_SIDE: state_in = ST_STEP;
         ST_STEP: state_in = at_limit ? ST_PREP : ST_CHECK;
         ST_CHECK: begin
            state_in = (oob_ff || rd_data_ff) ? ST_PREP : ST_STEP;
         end
         ST_PREP: state_in = perp_special ? ST_HPREP : ST_PDIV;
         ST_PDIV: begin
            if (div_done) state_in = ST_HPREP;
         end
         ST_HPREP: state_in = (perp_ff == '0) ? ST_OUT : ST_HDIV;
         ST_HDIV: begin
            if (div_done) state_in = ST_OUT;
         end
         ST_OUT: begin
            if (!rsp_full) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // control strobes
   always_comb begin
      cmd_pop      = 1'b0;
      mem_we       = 1'b0;
      mem_wd       = 1'b0;
      div_start    = 1'b0;
      div_dividend = DVD_W'(num_mag) << DIR_FRAC;
      div_divisor  = PERP_W'(dir_mag);
      rsp_push     = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            mem_we = 1'b1;
         end
         ST_IDLE: begin
            cmd_pop = !cmd_empty;
            mem_we  = !cmd_empty && (cmd.kind == CMD_WRITE);
            mem_wd  = cmd.is_wall;
         end
         ST_PREP: begin
            div_start = !perp_special;
         end
         ST_HPREP: begin
            div_start    = (perp_ff != '0);
            div_dividend = DVD_W'(SCREEN_H) << Q_FRAC;
            div_divisor  = perp_ff;
         end
         ST_OUT: begin
            rsp_push = !rsp_full;
         end
         default: begin
         end
      endcase
   end

   assign status.clearing = (state_ff == ST_CLEAR);
   assign status.busy     = (state_ff != ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_CLEAR;
         clr_cnt_ff <= '0;
      end else begin
         state_ff   <= state_in;
         clr_cnt_ff <= clr_cnt_in;
      end
   end

   assign clr_cnt_in = (state_ff == ST_CLEAR) ? clr_cnt_ff + AW'(1) : clr_cnt_ff;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         grid_mem[(state_ff == ST_CLEAR) ? clr_cnt_ff : wr_addr] <= mem_wd;
      end
      rd_data_ff <= grid_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         walk_x_ff   <= '0;
         walk_y_ff   <= '0;
         side_x_ff   <= '0;
         side_y_ff   <= '0;
         steps_ff    <= '0;
         side_ff     <= 1'b0;
         oob_ff      <= 1'b0;
         off_grid_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (!cmd_empty && cmd.kind == CMD_CAST) begin
                  walk_x_ff   <= XW'(cmd.cell_x);
                  walk_y_ff   <= XW'(cmd.cell_y);
                  steps_ff    <= '0;
                  side_ff     <= 1'b0;
                  oob_ff      <= 1'b0;
                  off_grid_ff <= 1'b0;
               end
            end
            ST_SIDE: begin
               side_x_ff <= SIDE_W'(prod_x_ff >> Q_FRAC);
               side_y_ff <= SIDE_W'(prod_y_ff >> Q_FRAC);
            end
            ST_STEP: begin
               if (at_limit) begin
                  off_grid_ff <= 1'b1;
               end else begin
                  if (step_x) begin
                     side_x_ff <= side_x_nx;
                     walk_x_ff <= walk_x_nx;
                     side_ff   <= 1'b0;
                  end else begin
                     side_y_ff <= side_y_nx;
                     walk_y_ff <= walk_y_nx;
                     side_ff   <= 1'b1;
                  end
                  steps_ff <= steps_ff + SW'(1);
                  oob_ff   <= oob_nx;
               end
            end
            ST_CHECK: begin
               if (oob_ff) off_grid_ff <= 1'b1;
            end
            default: begin
            end
         endcase
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && !cmd_empty && cmd.kind == CMD_CAST) begin
         neg_x_ff <= cmd.neg_x;
         neg_y_ff <= cmd.neg_y;
         dir_x_ff <= cmd.dir_x;
         dir_y_ff <= cmd.dir_y;
         ddx_ff   <= cmd.step_dist_x;
         ddy_ff   <= cmd.step_dist_y;
         off_x_ff <= cmd.off_x;
         off_y_ff <= cmd.off_y;
      end
      if (state_ff == ST_MUL) begin
         prod_x_ff <= PROD_W'(off_x_ff) * PROD_W'(ddx_ff);
         prod_y_ff <= PROD_W'(off_y_ff) * PROD_W'(ddy_ff);
      end
      if (state_ff == ST_PREP && perp_special) begin
         perp_ff <= perp_special_val;
      end else if (state_ff == ST_PDIV && div_done) begin
         perp_ff <= (div_quotient > DVD_W'(PERP_MAX)) ? PERP_MAX : PERP_W'(div_quotient);
      end
      if (state_ff == ST_HPREP && perp_ff == '0) begin
         height_ff <= HEIGHT_MAX;
      end else if (state_ff == ST_HDIV && div_done) begin
         height_ff <= (div_quotient > DVD_W'(HEIGHT_MAX)) ? HEIGHT_MAX
                                                           : HEIGHT_W'(div_quotient);
      end
   end

endmodule

/* rtl/grid_ray_dda_wall_column_core.sv */
// order: a grid write is written into the grid when the back part, idle, takes it from the
// command queue; a cast walks the grid cell by cell after the back part picks it up, then
// runs up to two serial divisions of the divider width (40 bits at the defaults)
// throughput: one item at a time in the back part, set by the serial divider and the
// one-read grid memory; two items queue in front, two results queue behind
// reset: clears control state, then sweeps all GRID_W*GRID_H grid cells to empty the grid
// -----------------------------------------------------------------------------
// grid_ray_dda_wall_column_core
// Wall grid ray caster: grid writes and DDA casts that return one wall column.
// -----------------------------------------------------------------------------
module grid_ray_dda_wall_column_core #(
   parameter int GRID_W     = gdda_pkg::GRID_W_DEF,
   parameter int GRID_H     = gdda_pkg::GRID_H_DEF,
   parameter int SCREEN_H   = gdda_pkg::SCREEN_H_DEF,
   parameter int STEP_LIMIT = gdda_pkg::STEP_LIMIT_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_push,
   output logic                                req_full,
   input  logic                                req_opcode,
   input  logic [gdda_pkg::CELL_W-1:0]         req_cell_x,
   input  logic [gdda_pkg::CELL_W-1:0]         req_cell_y,
   input  logic                                req_is_wall,
   input  logic signed [gdda_pkg::DIR_W-1:0]   req_dir_x,
   input  logic signed [gdda_pkg::DIR_W-1:0]   req_dir_y,
   input  logic [gdda_pkg::DIST_W-1:0]         req_step_dist_x,
   input  logic [gdda_pkg::DIST_W-1:0]         req_step_dist_y,
   output logic                                rsp_empty,
   input  logic                                rsp_pop,
   output logic [gdda_pkg::CELL_W-1:0]         rsp_hit_x,
   output logic [gdda_pkg::CELL_W-1:0]         rsp_hit_y,
   output logic                                rsp_hit_side,
   output logic [gdda_pkg::PERP_W-1:0]         rsp_perp_dist,
   output logic [gdda_pkg::HEIGHT_W-1:0]       rsp_column_height,
   output logic [gdda_pkg::DRAW_W-1:0]         rsp_draw_top,
   output logic [gdda_pkg::DRAW_W-1:0]         rsp_draw_bottom,
   output logic                                rsp_off_grid,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [gdda_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [gdda_pkg::VIEW_W-1:0]         csr_wdata
);
   import gdda_pkg::*;

   logic [VIEW_W-1:0] viewer_x_ff, viewer_x_in, viewer_y_ff, viewer_y_in;
   cmd_type           cmd_wr, cmd_rd;
   logic              cmd_full, cmd_empty, cmd_pop, cmd_push;
   rsp_type           rsp_wr, rsp_rd;
   logic              rsp_full, rsp_push;
   back_status_type   status;

   assign csr_ready = 1'b1;

   always_comb begin
      viewer_x_in = viewer_x_ff;
      viewer_y_in = viewer_y_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_VIEWER_X: viewer_x_in = csr_wdata;
            CSR_VIEWER_Y: viewer_y_in = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         viewer_x_ff <= '0;
         viewer_y_ff <= '0;
      end else begin
         viewer_x_ff <= viewer_x_in;
         viewer_y_ff <= viewer_y_in;
      end
   end

   // no items taken while the grid is being swept
   assign req_full = cmd_full || status.clearing;
   assign cmd_push = req_push && !req_full;

   gdda_front #(.GRID_W(GRID_W), .GRID_H(GRID_H)) u_front (
      .viewer_x    (viewer_x_ff),
      .viewer_y    (viewer_y_ff),
      .opcode      (req_opcode),
      .cell_x      (req_cell_x),
      .cell_y      (req_cell_y),
      .is_wall     (req_is_wall),
      .dir_x       (req_dir_x),
      .dir_y       (req_dir_y),
      .step_dist_x (req_step_dist_x),
      .step_dist_y (req_step_dist_y),
      .cmd         (cmd_wr)
   );

   gdda_fifo #(.W($bits(cmd_type)), .DEPTH(QUEUE_DEPTH)) u_cmd_q (
      .clock   (clock),
      .reset   (reset),
      .push    (cmd_push),
      .wr_data (cmd_wr),
      .full    (cmd_full),
      .pop     (cmd_pop),
      .rd_data (cmd_rd),
      .empty   (cmd_empty)
   );

   gdda_back #(
      .GRID_W     (GRID_W),
      .GRID_H     (GRID_H),
      .SCREEN_H   (SCREEN_H),
      .STEP_LIMIT (STEP_LIMIT)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .viewer_x  (viewer_x_ff),
      .viewer_y  (viewer_y_ff),
      .cmd       (cmd_rd),
      .cmd_empty (cmd_empty),
      .cmd_pop   (cmd_pop),
      .rsp_full  (rsp_full),
      .rsp_push  (rsp_push),
      .rsp       (rsp_wr),
      .status    (status)
   );

   gdda_fifo #(.W($bits(rsp_type)), .DEPTH(QUEUE_DEPTH)) u_rsp_q (
      .clock   (clock),
      .reset   (reset),
      .push    (rsp_push),
      .wr_data (rsp_wr),
      .full    (rsp_full),
      .pop     (rsp_pop),
      .rd_data (rsp_rd),
      .empty   (rsp_empty)
   );

   assign rsp_hit_x         = rsp_rd.hit_x;
   assign rsp_hit_y         = rsp_rd.hit_y;
   assign rsp_hit_side      = rsp_rd.hit_side;
   assign rsp_perp_dist     = rsp_rd.perp_dist;
   assign rsp_column_height = rsp_rd.column_height;
   assign rsp_draw_top      = rsp_rd.draw_top;
   assign rsp_draw_bottom   = rsp_rd.draw_bottom;
   assign rsp_off_grid      = rsp_rd.off_grid;

   a_clear_no_rsp: assert property (@(posedge clock) disable iff (reset)
      status.clearing |-> rsp_empty)
      else $error("result present during grid sweep");

   a_rsp_no_overflow: assert property (@(posedge clock) disable iff (reset)
      rsp_push |-> !rsp_full)
      else $error("result pushed into a full queue");

   a_zero_dist_height: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_perp_dist == '0) |-> (rsp_column_height == HEIGHT_MAX))
      else $error("zero distance without saturated height");

   a_pop_only_idle: assert property (@(posedge clock) disable iff (reset)
      cmd_pop |-> !status.busy)
      else $error("command taken while back part busy");

endmodule

/* tb/sv/gdda_checker.sv */
// -----------------------------------------------------------------------------
// gdda_checker
// Watches the request, response and csr channels of the DDA wall column core,
// keeps its own copy of the wall grid and viewer position, predicts each ray
// cast item and compares every popped item field by field.
// -----------------------------------------------------------------------------
module gdda_checker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_push,
   input  logic                                req_full,
   input  logic                                req_opcode,
   input  logic [gdda_pkg::CELL_W-1:0]         req_cell_x,
   input  logic [gdda_pkg::CELL_W-1:0]         req_cell_y,
   input  logic                                req_is_wall,
   input  logic signed [gdda_pkg::DIR_W-1:0]   req_dir_x,
   input  logic signed [gdda_pkg::DIR_W-1:0]   req_dir_y,
   input  logic [gdda_pkg::DIST_W-1:0]         req_step_dist_x,
   input  logic [gdda_pkg::DIST_W-1:0]         req_step_dist_y,
   input  logic                                rsp_empty,
   input  logic                                rsp_pop,
   input  logic [gdda_pkg::CELL_W-1:0]         rsp_hit_x,
   input  logic [gdda_pkg::CELL_W-1:0]         rsp_hit_y,
   input  logic                                rsp_hit_side,
   input  logic [gdda_pkg::PERP_W-1:0]         rsp_perp_dist,
   input  logic [gdda_pkg::HEIGHT_W-1:0]       rsp_column_height,
   input  logic [gdda_pkg::DRAW_W-1:0]         rsp_draw_top,
   input  logic [gdda_pkg::DRAW_W-1:0]         rsp_draw_bottom,
   input  logic                                rsp_off_grid,
   input  logic                                csr_valid,
   input  logic                                csr_ready,
   input  logic [gdda_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [gdda_pkg::VIEW_W-1:0]         csr_wdata,
   output int                                  errors,
   output int                                  outstanding,
   output int                                  off_grid_hits
);
   timeunit 1ns;
   timeprecision 1ps;
   import gdda_pkg::*;

   localparam longint SAT32 = 64'hFFFF_FFFF;
   localparam longint ONE_Q16 = 65536;

   bit          wall_map [GRID_W_DEF*GRID_H_DEF];
   longint      pos_x;
   longint      pos_y;
   rsp_type     column_q [$];

   function automatic longint first_line_len(longint offset, longint delta);
      longint p;
      if (offset < 0) offset = 0;
      p = (offset * delta) >>> 16;
      return (p > SAT32) ? SAT32 : p;
   endfunction

   function automatic longint face_distance(longint cell_pos, longint stp, longint view,
                                            longint dir);
      longint num;
      longint q;
      num = (cell_pos + ((stp < 0) ? 1 : 0)) * ONE_Q16 - view;
      if (dir == 0) return longint'(PERP_MAX);
      q = (num * 16384) / dir;
      if (q < 0) return 0;
      if (q > longint'(PERP_MAX)) return longint'(PERP_MAX);
      return q;
   endfunction

   function automatic rsp_type trace_column(longint cx, longint cy, longint dx, longint dy,
                                            longint ddx, longint ddy);
      longint  wx, wy, sx, sy, len_x, len_y, perp, height, top, bottom;
      int      n;
      bit      hit, off, side;
      rsp_type r;
      wx = cx;
      wy = cy;
      hit = 0;
      off = 0;
      side = 0;
      sx = (dx < 0) ? -1 : 1;
      sy = (dy < 0) ? -1 : 1;
      len_x = (dx < 0) ? first_line_len(pos_x - cx * ONE_Q16, ddx)
                       : first_line_len((cx + 1) * ONE_Q16 - pos_x, ddx);
      len_y = (dy < 0) ? first_line_len(pos_y - cy * ONE_Q16, ddy)
                       : first_line_len((cy + 1) * ONE_Q16 - pos_y, ddy);
      n = 0;
      while (!hit && n < STEP_LIMIT_DEF) begin
         // ties step along y
         if (len_x < len_y) begin
            len_x = len_x + ddx;
            if (len_x > SAT32) len_x = SAT32;
            wx += sx;
            side = 0;
         end else begin
            len_y = len_y + ddy;
            if (len_y > SAT32) len_y = SAT32;
            wy += sy;
            side = 1;
         end
         n++;
         if (wx < 0 || wx >= GRID_W_DEF || wy < 0 || wy >= GRID_H_DEF) begin
            hit = 1;
            off = 1;
         end else if (wall_map[wy * GRID_W_DEF + wx]) begin
            hit = 1;
         end
      end
      if (!hit) off = 1;
      perp = (side == 0) ? face_distance(wx, sx, pos_x, dx) : face_distance(wy, sy, pos_y, dy);
      if (perp == 0) begin
         height = longint'(HEIGHT_MAX);
      end else begin
         height = (longint'(SCREEN_H_DEF) << 16) / perp;
         if (height > longint'(HEIGHT_MAX)) height = longint'(HEIGHT_MAX);
      end
      top = SCREEN_H_DEF / 2 - height / 2 + SCREEN_H_DEF / 8;
      if (top < 0) top = 0;
      bottom = SCREEN_H_DEF / 2 + height / 2 + SCREEN_H_DEF / 8;
      if (bottom >= SCREEN_H_DEF) bottom = SCREEN_H_DEF - 1;
      r.hit_x = wx[CELL_W-1:0];
      r.hit_y = wy[CELL_W-1:0];
      r.hit_side = side;
      r.perp_dist = perp[PERP_W-1:0];
      r.column_height = height[HEIGHT_W-1:0];
      r.draw_top = top[DRAW_W-1:0];
      r.draw_bottom = bottom[DRAW_W-1:0];
      r.off_grid = off;
      return r;
   endfunction

   task automatic check_field(string name, longint want, longint got);
      if (want != got) begin
         $display("%0t ns: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
         errors++;
      end
   endtask

   initial begin
      errors = 0;
      outstanding = 0;
      off_grid_hits = 0;
   end

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         foreach (wall_map[i]) wall_map[i] = 0;
         pos_x = 0;
         pos_y = 0;
         column_q.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_VIEWER_X: pos_x = longint'(csr_wdata);
               CSR_VIEWER_Y: pos_y = longint'(csr_wdata);
               default: ;
            endcase
         end
         if (rsp_pop && !rsp_empty) begin
            if (column_q.size() == 0) begin
               $display("%0t ns: unexpected column item, expected none, got hit %0d,%0d",
                        $time, rsp_hit_x, rsp_hit_y);
               errors++;
            end else begin
               want = column_q.pop_front();
               if (want.off_grid) off_grid_hits++;
               check_field("hit_x", want.hit_x, rsp_hit_x);
               check_field("hit_y", want.hit_y, rsp_hit_y);
               check_field("hit_side", want.hit_side, rsp_hit_side);
               check_field("perp_dist", want.perp_dist, rsp_perp_dist);
               check_field("column_height", want.column_height, rsp_column_height);
               check_field("draw_top", want.draw_top, rsp_draw_top);
               check_field("draw_bottom", want.draw_bottom, rsp_draw_bottom);
               check_field("off_grid", want.off_grid, rsp_off_grid);
            end
         end
         if (req_push && !req_full) begin
            if (req_opcode == OP_WRITE)
               wall_map[int'(req_cell_y) * GRID_W_DEF + int'(req_cell_x)] = req_is_wall;
            else
               column_q.push_back(trace_column(longint'(req_cell_x), longint'(req_cell_y),
                                               longint'(req_dir_x), longint'(req_dir_y),
                                               longint'(req_step_dist_x),
                                               longint'(req_step_dist_y)));
         end
      end
      outstanding = column_q.size();
   end

endmodule

/* tb/sv/tb.sv */
// -----------------------------------------------------------------------------
// tb
// Stimulus for the DDA wall column core: directed grid writes and ray casts on
// the edge cases, then random rooms and rays over several viewer positions,
// with random stalls on both sides and one long response hold-off.
// -----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import gdda_pkg::*;

   logic                      clock;
   logic                      reset;
   logic                      req_push;
   logic                      req_full;
   logic                      req_opcode;
   logic [CELL_W-1:0]         req_cell_x;
   logic [CELL_W-1:0]         req_cell_y;
   logic                      req_is_wall;
   logic signed [DIR_W-1:0]   req_dir_x;
   logic signed [DIR_W-1:0]   req_dir_y;
   logic [DIST_W-1:0]         req_step_dist_x;
   logic [DIST_W-1:0]         req_step_dist_y;
   logic                      rsp_empty;
   logic                      rsp_pop;
   logic [CELL_W-1:0]         rsp_hit_x;
   logic [CELL_W-1:0]         rsp_hit_y;
   logic                      rsp_hit_side;
   logic [PERP_W-1:0]         rsp_perp_dist;
   logic [HEIGHT_W-1:0]       rsp_column_height;
   logic [DRAW_W-1:0]         rsp_draw_top;
   logic [DRAW_W-1:0]         rsp_draw_bottom;
   logic                      rsp_off_grid;
   logic                      csr_valid;
   logic                      csr_ready;
   logic [CSR_IDX_W-1:0]      csr_index;
   logic [VIEW_W-1:0]         csr_wdata;

   int errors;
   int outstanding;
   int off_grid_hits;
   int casts_sent;
   int writes_sent;
   int columns_popped;
   int viewer_moves;
   bit hold_done;

   grid_ray_dda_wall_column_core i_dut (.*);

   gdda_checker i_checker (.*);

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   initial begin
      #20ms;
      $display("timeout");
      $display("simulation failed");
      $finish;
   end

   // response side: random pops, one long hold-off so the queues back up
   always @(negedge clock) begin
      int r;
      if (reset) begin
         rsp_pop = 1'b0;
      end else if (!hold_done && columns_popped >= 30) begin
         hold_done = 1;
         rsp_pop = 1'b0;
         repeat (600) @(negedge clock);
      end else begin
         r = $urandom_range(0, 99);
         if (r < 70) begin
            rsp_pop = 1'b1;
         end else begin
            rsp_pop = 1'b0;
            repeat ((r < 95) ? $urandom_range(1, 3) : $urandom_range(10, 40)) @(negedge clock);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_pop && !rsp_empty) columns_popped++;
   end

   task automatic send_item(logic op, logic [5:0] cx, logic [5:0] cy, logic wall,
                            logic [15:0] dx, logic [15:0] dy, logic [23:0] sdx,
                            logic [23:0] sdy);
      int r;
      req_opcode = op;
      req_cell_x = cx;
      req_cell_y = cy;
      req_is_wall = wall;
      req_dir_x = dx;
      req_dir_y = dy;
      req_step_dist_x = sdx;
      req_step_dist_y = sdy;
      req_push = 1'b1;
      do @(posedge clock); while (req_full);
      if (op == OP_CAST) casts_sent++;
      else writes_sent++;
      @(negedge clock);
      r = $urandom_range(0, 99);
      if (r >= 65) begin
         req_push = 1'b0;
         repeat ((r < 95) ? $urandom_range(1, 3) : $urandom_range(10, 40)) @(negedge clock);
      end
   endtask

   task automatic set_cell(int x, int y, bit wall);
      send_item(OP_WRITE, x[5:0], y[5:0], wall, 16'($urandom), 16'($urandom),
                24'($urandom), 24'($urandom));
   endtask

   task automatic cast_ray(int x, int y, logic [15:0] dx, logic [15:0] dy,
                           logic [23:0] sdx, logic [23:0] sdy);
      send_item(OP_CAST, x[5:0], y[5:0], 1'($urandom), dx, dy, sdx, sdy);
   endtask

   task automatic move_viewer(logic [VIEW_W-1:0] vx, logic [VIEW_W-1:0] vy);
      req_push = 1'b0;
      wait (columns_popped == casts_sent);
      // a trailing grid write may still be settling
      repeat (20) @(negedge clock);
      for (int i = 0; i < 2; i++) begin
         csr_valid = 1'b1;
         csr_index = (i == 0) ? CSR_VIEWER_X : CSR_VIEWER_Y;
         csr_wdata = (i == 0) ? vx : vy;
         do @(posedge clock); while (!csr_ready);
         @(negedge clock);
         csr_valid = 1'b0;
      end
      viewer_moves++;
   endtask

   task automatic random_phase(int count);
      int vx;
      int vy;
      int r;
      logic [23:0] sdx;
      logic [23:0] sdy;
      for (int n = 0; n < count; n++) begin
         r = $urandom_range(0, 99);
         if (r < 40) begin
            set_cell($urandom_range(0, 63), $urandom_range(0, 63), $urandom_range(0, 99) < 35);
         end else begin
            // viewer-relative rays most of the time, as a renderer would issue them
            vx = int'(i_checker.pos_x >>> 16);
            vy = int'(i_checker.pos_y >>> 16);
            if ($urandom_range(0, 99) < 30) begin
               vx = $urandom_range(0, 63);
               vy = $urandom_range(0, 63);
            end
            r = $urandom_range(0, 99);
            sdx = (r < 60) ? 24'($urandom_range(0, 24'h7FFFF))
                           : (r < 90) ? 24'($urandom) : 24'hFFFFFF;
            r = $urandom_range(0, 99);
            sdy = (r < 60) ? 24'($urandom_range(0, 24'h7FFFF))
                           : (r < 90) ? 24'($urandom) : 24'h000000;
            cast_ray(vx, vy, 16'($urandom), 16'($urandom), sdx, sdy);
         end
      end
   endtask

   initial begin
      req_push = 1'b0;
      req_opcode = OP_WRITE;
      req_cell_x = '0;
      req_cell_y = '0;
      req_is_wall = 1'b0;
      req_dir_x = '0;
      req_dir_y = '0;
      req_step_dist_x = '0;
      req_step_dist_y = '0;
      csr_valid = 1'b0;
      csr_index = CSR_VIEWER_X;
      csr_wdata = '0;
      rsp_pop = 1'b0;
      casts_sent = 0;
      writes_sent = 0;
      columns_popped = 0;
      viewer_moves = 0;
      hold_done = 0;
      reset = 1'b1;
      repeat (4) @(negedge clock);
      reset = 1'b0;

      // empty grid at reset viewer: rays leave the grid
      cast_ray(0, 0, 16'h8000, 16'h8000, 24'h010000, 24'h010000);
      cast_ray(0, 0, 16'h0000, 16'h0000, 24'h000000, 24'h000000);
      move_viewer(22'h1F8000, 22'h208000);
      set_cell(32, 32, 1);
      set_cell(63, 63, 1);
      set_cell(0, 0, 1);
      set_cell(31, 40, 1);
      set_cell(63, 63, 0);
      cast_ray(31, 32, 16'h4000, 16'h0000, 24'h010000, 24'hFFFFFF);
      cast_ray(31, 32, 16'h0000, 16'h4000, 24'hFFFFFF, 24'h010000);
      cast_ray(31, 32, 16'h7FFF, 16'h7FFF, 24'hFFFFFF, 24'hFFFFFF);
      cast_ray(31, 32, 16'h8000, 16'h8000, 24'h000000, 24'h000000);
      cast_ray(31, 32, 16'h0000, 16'h0000, 24'h016A0A, 24'h016A0A);
      // start cell away from the viewer; the last cast has a clamped start offset
      cast_ray(5, 60, 16'hC000, 16'h2000, 24'h020000, 24'h030000);
      cast_ray(60, 5, 16'h3000, 16'hD000, 24'h012345, 24'h00ABCD);
      cast_ray(63, 63, 16'h0001, 16'hFFFF, 24'h000001, 24'hFFFFFE);
      move_viewer(22'h3FFFFF, 22'h3FFFFF);
      // viewer beyond the hit wall: negative distance
      cast_ray(0, 0, 16'h4000, 16'h4000, 24'h010000, 24'h010000);
      cast_ray(1, 0, 16'hC000, 16'h0100, 24'h010000, 24'h400000);

      move_viewer(22'h1F8000, 22'h208000);
      random_phase(100);
      move_viewer(22'h000000, 22'h000000);
      random_phase(100);
      move_viewer(22'h3FFFFF, 22'h3FFFFF);
      random_phase(100);
      move_viewer(VIEW_W'($urandom), VIEW_W'($urandom));
      random_phase(100);
      move_viewer(VIEW_W'($urandom), VIEW_W'($urandom));
      random_phase(100);

      req_push = 1'b0;
      wait (columns_popped == casts_sent);
      repeat (200) @(negedge clock);
      $display("covered %0d ray casts (%0d left the grid) and %0d grid writes",
               casts_sent, off_grid_hits, writes_sent);
      $display("over %0d viewer positions, with one long response stall", viewer_moves);
      if (errors == 0 && outstanding == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
